// ----- hdl/tsrc_pkg.sv -----
`timescale 1ns / 1ps

package tsrc_pkg;

  // Field and register widths
  localparam int TIME_W_DEF = 32;
  localparam int ANGLE_W    = 8;
  localparam int DUR_W      = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = ANGLE_W + DUR_W;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_UNDEF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REST    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FISH    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRAVEL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POSDROP = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DROP    = 3'd5;

  // Angle limits and register reset values
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_RST = 8'd90;
  localparam logic [DUR_W-1:0]   DUR_RST   = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARM_REST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_FISH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_TRAVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_DROP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REL_REST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REL_DROP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DUR    = 3'd6;

  // Sequencer step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
  localparam logic [PC_W-1:0] PC_SETUP    = 3'd1;
  localparam logic [PC_W-1:0] PC_MUL      = 3'd2;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 3'd3;
  localparam logic [PC_W-1:0] PC_DIV      = 3'd4;
  localparam logic [PC_W-1:0] PC_FINISH   = 3'd5;
  localparam logic [PC_W-1:0] PC_RETURN   = 3'd6;

  // Datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP      = 3'd0;
  localparam logic [OP_W-1:0] OP_SETUP    = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL      = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 3'd4;
  localparam logic [OP_W-1:0] OP_FINISH   = 3'd5;

  // Jump conditions: jump to target when true, else fall through
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT      = 3'd0;
  localparam logic [COND_W-1:0] C_NO_START  = 3'd1;
  localparam logic [COND_W-1:0] C_HOLD      = 3'd2;
  localparam logic [COND_W-1:0] C_DIV_BUSY  = 3'd3;
  localparam logic [COND_W-1:0] C_OUT_BLOCK = 3'd4;
  localparam logic [COND_W-1:0] C_ALWAYS    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_IDLE:     w = '{op: OP_NOP,      cond: C_NO_START,  target: PC_IDLE};
      PC_SETUP:    w = '{op: OP_SETUP,    cond: C_NEXT,      target: PC_IDLE};
      PC_MUL:      w = '{op: OP_MUL,      cond: C_HOLD,      target: PC_FINISH};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,      target: PC_IDLE};
      PC_DIV:      w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,  target: PC_DIV};
      PC_FINISH:   w = '{op: OP_FINISH,   cond: C_OUT_BLOCK, target: PC_FINISH};
      PC_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PC_IDLE};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

  // Limit a servo angle to the mechanical maximum
  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W:0] a);
    return (a > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : a[ANGLE_W-1:0];
  endfunction

endpackage

// ----- hdl/tsrc_if.sv -----
`timescale 1ns / 1ps

// Update item channel
interface tsrc_in_if #(
  parameter int TW = tsrc_pkg::TIME_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic [TW-1:0]                 now_ms;
  logic                          set_request;
  logic [tsrc_pkg::MODE_W-1:0]   requested_mode;

  modport source (output valid, now_ms, set_request, requested_mode, input ready);
  modport sink   (input valid, now_ms, set_request, requested_mode, output ready);
endinterface

// Servo command channel
interface tsrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsrc_pkg::ANGLE_W-1:0]  arm_angle;
  logic [tsrc_pkg::ANGLE_W-1:0]  release_angle;

  modport source (output valid, arm_angle, release_angle, input ready);
  modport sink   (input valid, arm_angle, release_angle, output ready);
endinterface

// Register write channel
interface tsrc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tsrc_pkg::CFG_IDX_W-1:0]  index;
  logic [tsrc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/tsrc_div.sv -----
`timescale 1ns / 1ps

module tsrc_div #(
  parameter int N_W = tsrc_pkg::PROD_W,
  parameter int D_W = tsrc_pkg::DUR_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsrc_pkg::div_ctl_t ctl,
  input  logic [N_W-1:0]     dividend,
  input  logic [D_W-1:0]     divisor,
  output logic [N_W-1:0]     quotient,
  output logic               busy
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo_r;
  logic [D_W-1:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [D_W:0]     trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[N_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Restoring division, one quotient bit a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= CNT_W'(N_W);
    end else if (ctl.step && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (ctl.step && cnt_r != '0) begin
      quo_r <= {quo_r[N_W-2:0], fits};
      rem_r <= fits ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign busy     = cnt_r != '0;

endmodule

// ----- hdl/timed_servo_ramp_controller.sv -----
`timescale 1ns / 1ps
// A ramping update runs the setup, multiply, divide-init, divide and finish steps; the
// divide step uses a 24-step restoring divider. When the arm holds its target or the mode
// is undefined, multiply jumps straight to finish. New items are taken only in the idle step,
// after the last one is through; a result waiting on out_if stalls only the finish step.
// Reset (rst_n, synchronous, active low) loads register defaults and clears mode,
// ramp and sequencer state; there is no clearing pass.
module timed_servo_ramp_controller #(
  parameter int TIME_WIDTH = tsrc_pkg::TIME_W_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsrc_in_if.sink    in_if,
  tsrc_out_if.source out_if,
  tsrc_cfg_if.sink   cfg_if
);

  localparam int AW = tsrc_pkg::ANGLE_W;
  localparam int DW = tsrc_pkg::DUR_W;
  localparam int MW = tsrc_pkg::MODE_W;
  localparam int PW = tsrc_pkg::PROD_W;

  // Configuration registers
  logic [AW-1:0] arm_rest_r, arm_fish_r, arm_travel_r, arm_drop_r;
  logic [AW-1:0] rel_rest_r, rel_drop_r;
  logic [DW-1:0] dur_r;

  // Mode and ramp state
  logic [MW-1:0]         asked_r, prev_r, mode_r;
  logic [TIME_WIDTH-1:0] change_r, now_r;
  logic [AW-1:0]         start_r, last_arm_r;

  // Per-item working registers
  logic [DW-1:0] elapsed_r;
  logic          hold_r, up_r;
  logic [AW-1:0] diff_r, tgt_r;
  logic [PW-1:0] prod_r;

  // Output register
  logic          out_valid_r;
  logic [AW-1:0] out_arm_r, out_rel_r;

  // Sequencer
  logic [tsrc_pkg::PC_W-1:0] pc_r, pc_nxt;
  tsrc_pkg::ucode_t          cw;
  logic                      jump;

  logic in_acc, out_acc, cfg_acc, div_busy;
  logic [PW-1:0] quotient;
  tsrc_pkg::div_ctl_t div_ctl;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;

  assign in_if.ready      = pc_r == tsrc_pkg::PC_IDLE;
  assign cfg_if.ready     = 1'b1;
  assign out_if.valid     = out_valid_r;
  assign out_if.arm_angle = out_arm_r;
  assign out_if.release_angle = out_rel_r;

  // Fetch the control word and resolve the jump
  always_comb begin
    cw = tsrc_pkg::ucode_rom(pc_r);
    case (cw.cond)
      tsrc_pkg::C_NEXT:      jump = 1'b0;
      tsrc_pkg::C_NO_START:  jump = !in_acc;
      tsrc_pkg::C_HOLD:      jump = hold_r;
      tsrc_pkg::C_DIV_BUSY:  jump = div_busy;
      tsrc_pkg::C_OUT_BLOCK: jump = out_valid_r && !out_if.ready;
      tsrc_pkg::C_ALWAYS:    jump = 1'b1;
      default:               jump = 1'b1;
    endcase
    pc_nxt = jump ? cw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tsrc_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_rest_r   <= tsrc_pkg::ANGLE_RST;
      arm_fish_r   <= tsrc_pkg::ANGLE_RST;
      arm_travel_r <= tsrc_pkg::ANGLE_RST;
      arm_drop_r   <= tsrc_pkg::ANGLE_RST;
      rel_rest_r   <= tsrc_pkg::ANGLE_RST;
      rel_drop_r   <= tsrc_pkg::ANGLE_RST;
      dur_r        <= tsrc_pkg::DUR_RST;
    end else if (cfg_acc) begin
      case (cfg_if.index)
        tsrc_pkg::REG_ARM_REST:   arm_rest_r   <= cfg_if.data[AW-1:0];
        tsrc_pkg::REG_ARM_FISH:   arm_fish_r   <= cfg_if.data[AW-1:0];
        tsrc_pkg::REG_ARM_TRAVEL: arm_travel_r <= cfg_if.data[AW-1:0];
        tsrc_pkg::REG_ARM_DROP:   arm_drop_r   <= cfg_if.data[AW-1:0];
        tsrc_pkg::REG_REL_REST:   rel_rest_r   <= cfg_if.data[AW-1:0];
        tsrc_pkg::REG_REL_DROP:   rel_drop_r   <= cfg_if.data[AW-1:0];
        tsrc_pkg::REG_RAMP_DUR:   dur_r        <= cfg_if.data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Mode bookkeeping at accept
  logic [MW-1:0] eff_mode;
  always_comb begin
    eff_mode = asked_r;
    if (in_if.set_request &&
        (in_if.requested_mode inside {[tsrc_pkg::MODE_UNDEF:tsrc_pkg::MODE_DROP]})) begin
      eff_mode = in_if.requested_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asked_r  <= tsrc_pkg::MODE_UNDEF;
      prev_r   <= tsrc_pkg::MODE_UNDEF;
      change_r <= '0;
      start_r  <= '0;
    end else if (in_acc) begin
      // undefined moves on to rest by itself
      asked_r <= (eff_mode == tsrc_pkg::MODE_UNDEF) ? tsrc_pkg::MODE_REST : eff_mode;
      if (eff_mode != prev_r) begin
        prev_r   <= eff_mode;
        change_r <= in_if.now_ms;
        start_r  <= last_arm_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= eff_mode;
      now_r  <= in_if.now_ms;
    end
  end

  // Setup step: elapsed time, target, direction and hold decision
  logic [TIME_WIDTH-1:0] elapsed;
  logic [AW-1:0]         tgt_sel;
  always_comb begin
    elapsed = now_r - change_r;
    case (mode_r)
      tsrc_pkg::MODE_REST:    tgt_sel = arm_rest_r;
      tsrc_pkg::MODE_FISH:    tgt_sel = arm_fish_r;
      tsrc_pkg::MODE_TRAVEL:  tgt_sel = arm_travel_r;
      tsrc_pkg::MODE_POSDROP: tgt_sel = arm_drop_r;
      tsrc_pkg::MODE_DROP:    tgt_sel = arm_drop_r;
      default:                tgt_sel = last_arm_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.op == tsrc_pkg::OP_SETUP) begin
      elapsed_r <= elapsed[DW-1:0];
      hold_r    <= (mode_r == tsrc_pkg::MODE_UNDEF) ||
                   (elapsed >= TIME_WIDTH'(dur_r));
      tgt_r     <= tgt_sel;
      up_r      <= tgt_sel >= start_r;
      diff_r    <= (tgt_sel >= start_r) ? tgt_sel - start_r : start_r - tgt_sel;
    end
  end

  // Multiply step: span times elapsed
  always_ff @(posedge clk) begin
    if (cw.op == tsrc_pkg::OP_MUL) begin
      prod_r <= PW'(diff_r) * PW'(elapsed_r);
    end
  end

  // Divide: round down when rising, up when falling
  logic [PW-1:0] dividend;
  assign dividend = up_r ? prod_r : prod_r + PW'(dur_r) - 1'b1;
  assign div_ctl.start = cw.op == tsrc_pkg::OP_DIV_INIT;
  assign div_ctl.step  = cw.op == tsrc_pkg::OP_DIV_STEP;

  tsrc_div #(
    .N_W(PW),
    .D_W(DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .dividend(dividend),
    .divisor (dur_r),
    .quotient(quotient),
    .busy    (div_busy)
  );

  // Finish step: final arm and release angles
  logic [AW-1:0] q8, arm_fin, rel_fin;
  logic [AW:0]   ramp_val;
  always_comb begin
    q8       = quotient[AW-1:0];
    ramp_val = up_r ? {1'b0, start_r} + {1'b0, q8} : {1'b0, start_r - q8};
    if (mode_r == tsrc_pkg::MODE_UNDEF) begin
      arm_fin = last_arm_r;
    end else if (hold_r) begin
      arm_fin = tsrc_pkg::clamp_angle({1'b0, tgt_r});
    end else begin
      arm_fin = tsrc_pkg::clamp_angle(ramp_val);
    end
    rel_fin = (mode_r == tsrc_pkg::MODE_DROP) ? tsrc_pkg::clamp_angle({1'b0, rel_drop_r})
                                              : tsrc_pkg::clamp_angle({1'b0, rel_rest_r});
  end

  logic finish_go;
  assign finish_go = (cw.op == tsrc_pkg::OP_FINISH) && !(out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_arm_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (finish_go) begin
      last_arm_r  <= arm_fin;
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_arm_r <= arm_fin;
      out_rel_r <= rel_fin;
    end
  end

  // A new result only comes out of the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == tsrc_pkg::PC_FINISH)
    else $error("result raised outside the finish step");

  // Commanded angles stay within servo range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_arm_r <= tsrc_pkg::ANGLE_MAX && out_rel_r <= tsrc_pkg::ANGLE_MAX))
    else $error("servo angle above limit");

  // Undefined never survives an update
  a_mode_leaves_undef: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> asked_r != tsrc_pkg::MODE_UNDEF)
    else $error("stored mode still undefined after update");

  // The divider is done before the finish step uses its quotient
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tsrc_pkg::PC_FINISH) |-> !div_busy)
    else $error("finish step reached with divider busy");

endmodule
